[src/sbe_pkg.sv]
`timescale 1ns / 1ps

package sbe_pkg;

	localparam int DATA_WIDTH  = 32;
	localparam int STACK_DEPTH = 64;
	localparam int LOCAL_COUNT = 256;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int SA_W        = $clog2(STACK_DEPTH);
	localparam int LA_W        = $clog2(LOCAL_COUNT);
	localparam int NLOC_W      = 9;
	localparam logic [NLOC_W-1:0] NLOC_RESET = NLOC_W'(256);

	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef enum logic [4:0] {
		K_PUSHC = 5'd0,  K_TRUE  = 5'd1,  K_FALSE = 5'd2,
		K_ADD   = 5'd3,  K_SUB   = 5'd4,  K_MUL   = 5'd5,  K_DIV  = 5'd6,  K_MOD  = 5'd7,
		K_ADDS  = 5'd8,  K_SUBS  = 5'd9,  K_MULS  = 5'd10, K_DIVS = 5'd11,
		K_GT    = 5'd12, K_GTE   = 5'd13, K_LT    = 5'd14, K_LTE  = 5'd15,
		K_IEQ   = 5'd16, K_BEQ   = 5'd17, K_INEQ  = 5'd18, K_BNEQ = 5'd19,
		K_NEG   = 5'd20, K_NOT   = 5'd21, K_LOAD  = 5'd22, K_STORE = 5'd23,
		K_JMP   = 5'd24, K_JMPN  = 5'd25, K_JMPT  = 5'd26
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_DIV_ZERO  = 3'd1,
		ST_BAD_SLOT  = 3'd2,
		ST_UNDERFLOW = 3'd3,
		ST_OVERFLOW  = 3'd4,
		ST_HALTED    = 3'd5
	} status_t;

	typedef struct packed {
		logic [4:0]         kind;
		logic [15:0]        operand_word;
		logic signed [31:0] constant_value;
	} sbe_in_t;

	typedef struct packed {
		logic [15:0]        next_pc;
		logic signed [31:0] top_value;
		logic [6:0]         stack_depth;
		logic [2:0]         status;
	} sbe_out_t;

	typedef struct packed {
		logic capture;
		logic start_div;
		logic commit;
	} sbe_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} sbe_stat_t;

	function automatic logic [1:0] kind_len(input logic [4:0] k);
		logic [1:0] len;
		len = 2'd1;
		if (k == K_PUSHC || (k >= K_ADDS && k <= K_DIVS) || (k >= K_LOAD && k <= K_JMPT))
			len = 2'd3;
		return len;
	endfunction

endpackage

[src/sbe_ram.sv]
`timescale 1ns / 1ps

module sbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

[src/sbe_div.sv]
`timescale 1ns / 1ps

module sbe_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sbe_pkg::DATA_WIDTH-1:0] dividend,
	input  logic [sbe_pkg::DATA_WIDTH-1:0] divisor,
	output logic [sbe_pkg::DATA_WIDTH-1:0] quot,
	output logic [sbe_pkg::DATA_WIDTH-1:0] rem,
	output logic                      done
);
	import sbe_pkg::*;

	localparam int CNT_W = $clog2(DATA_WIDTH + 1);

	data_t            rem_q, quo_q, dvs_q;
	logic             neg_a_q, neg_q_q, busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DATA_WIDTH:0] rem_sh, rem_sub;

	assign rem_sh  = {rem_q, quo_q[DATA_WIDTH-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done   <= 1'b0;
			cnt_q  <= CNT_W'(DATA_WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_a_q <= dividend[DATA_WIDTH-1];
			neg_q_q <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
			quo_q   <= dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
			dvs_q   <= divisor[DATA_WIDTH-1] ? (~divisor + 1'b1) : divisor;
			rem_q   <= '0;
		end else if (busy_q) begin
			if (!rem_sub[DATA_WIDTH]) begin
				rem_q <= rem_sub[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DATA_WIDTH-1:0];
				quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign quot = neg_q_q ? (~quo_q + 1'b1) : quo_q;
	assign rem  = neg_a_q ? (~rem_q + 1'b1) : rem_q;

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done)) else $error("divider busy and done together");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && !done) else $error("divider did not start");

endmodule

[src/sbe_datapath.sv]
`timescale 1ns / 1ps

module sbe_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  sbe_pkg::sbe_in_t   in_data,
	input  logic               cfg_we,
	input  logic [8:0]         cfg_wdata,
	input  sbe_pkg::sbe_cmd_t  cmd,
	output sbe_pkg::sbe_stat_t stat,
	output sbe_pkg::sbe_out_t  out_data
);
	import sbe_pkg::*;

	sbe_in_t           item_q;
	logic [SP_W-1:0]   sp_q, sp_n;
	logic [15:0]       pc_q, pc_n, target;
	logic              halted_q, halt;
	logic [NLOC_W-1:0] nloc_q;
	data_t             tos_q, tos_n, a2, loc, r, val, div_quot, div_rem, dvd;
	logic              stk_we, loc_we, need_div, jump, slot_ok, full, ge1, ge2, bz;
	logic [SA_W-1:0]   stk_wa, stk_ra;
	data_t             stk_wd, loc_wd;
	status_t           status;
	logic [4:0]        k;

	assign stk_ra  = SA_W'(sp_q - SP_W'(2));
	assign k       = item_q.kind;
	assign target  = pc_q + 16'd3 + item_q.operand_word;
	assign slot_ok = ({7'd0, nloc_q} > item_q.operand_word)
		&& (item_q.operand_word < 16'(LOCAL_COUNT));
	assign full    = sp_q >= SP_W'(STACK_DEPTH);
	assign ge1     = sp_q != '0;
	assign ge2     = sp_q >= SP_W'(2);
	assign bz      = tos_q == '0;
	assign dvd     = (k == K_DIVS) ? loc : a2;

	sbe_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(stk_we & cmd.commit), .waddr(stk_wa), .wdata(stk_wd),
		.re(cmd.capture), .raddr(stk_ra), .rdata(a2)
	);

	sbe_ram #(.WIDTH(DATA_WIDTH), .DEPTH(LOCAL_COUNT)) u_locals (
		.clk(clk), .we(loc_we & cmd.commit), .waddr(item_q.operand_word[LA_W-1:0]),
		.wdata(loc_wd), .re(cmd.capture), .raddr(in_data.operand_word[LA_W-1:0]),
		.rdata(loc)
	);

	sbe_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.start_div), .dividend(dvd),
		.divisor(tos_q), .quot(div_quot), .rem(div_rem), .done(stat.div_done)
	);

	always_comb begin
		unique case (k)
			K_ADD:         r = a2 + tos_q;
			K_ADDS:        r = loc + tos_q;
			K_SUB:         r = a2 - tos_q;
			K_SUBS:        r = loc - tos_q;
			K_MUL:         r = DATA_WIDTH'(a2 * tos_q);
			K_MULS:        r = DATA_WIDTH'(loc * tos_q);
			K_DIV, K_DIVS: r = div_quot;
			K_MOD:         r = div_rem;
			K_GT:          r = data_t'($signed(tos_q) < $signed(a2));
			K_GTE:         r = data_t'(!($signed(a2) < $signed(tos_q)));
			K_LT:          r = data_t'($signed(a2) < $signed(tos_q));
			K_LTE:         r = data_t'(!($signed(tos_q) < $signed(a2)));
			K_IEQ:         r = data_t'(a2 == tos_q);
			K_BEQ:         r = data_t'((a2 != '0) == (tos_q != '0));
			K_INEQ:        r = data_t'(a2 != tos_q);
			K_BNEQ:        r = data_t'((a2 != '0) != (tos_q != '0));
			K_NEG:         r = ~tos_q + 1'b1;
			K_NOT:         r = data_t'(bz);
			default:       r = loc + tos_q;
		endcase
	end

	always_comb begin
		status   = ST_OK;
		halt     = 1'b0;
		jump     = 1'b0;
		need_div = 1'b0;
		sp_n     = sp_q;
		tos_n    = tos_q;
		stk_we   = 1'b0;
		stk_wa   = SA_W'(sp_q);
		stk_wd   = r;
		loc_we   = 1'b0;
		loc_wd   = r;
		val      = (k == K_PUSHC) ? data_t'(item_q.constant_value) :
			(k == K_TRUE) ? data_t'(1) : (k == K_LOAD) ? loc : '0;
		if (halted_q) begin
			status = ST_HALTED;
			halt   = 1'b1;
		end else begin
			unique case (k)
				K_PUSHC, K_TRUE, K_FALSE: begin
					if (full) begin
						status = ST_OVERFLOW;
						halt   = 1'b1;
					end else begin
						stk_we = 1'b1;
						stk_wd = val;
						tos_n  = val;
						sp_n   = sp_q + 1'b1;
					end
				end
				K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_GT, K_GTE, K_LT, K_LTE,
				K_IEQ, K_BEQ, K_INEQ, K_BNEQ: begin
					if (!ge2) begin
						status = ST_UNDERFLOW;
						halt   = 1'b1;
					end else if ((k == K_DIV || k == K_MOD) && bz) begin
						status = ST_DIV_ZERO;
					end else begin
						need_div = (k == K_DIV || k == K_MOD);
						stk_we   = 1'b1;
						stk_wa   = SA_W'(sp_q - SP_W'(2));
						tos_n    = r;
						sp_n     = sp_q - 1'b1;
					end
				end
				K_ADDS, K_SUBS, K_MULS, K_DIVS: begin
					if (!ge1) begin
						status = ST_UNDERFLOW;
						halt   = 1'b1;
					end else if (!slot_ok) begin
						status = ST_BAD_SLOT;
						halt   = 1'b1;
					end else if (k == K_DIVS && bz) begin
						status = ST_DIV_ZERO;
					end else begin
						need_div = (k == K_DIVS);
						loc_we   = 1'b1;
						tos_n    = a2;
						sp_n     = sp_q - 1'b1;
					end
				end
				K_NEG, K_NOT: begin
					if (!ge1) begin
						status = ST_UNDERFLOW;
						halt   = 1'b1;
					end else begin
						stk_we = 1'b1;
						stk_wa = SA_W'(sp_q - 1'b1);
						tos_n  = r;
					end
				end
				K_LOAD: begin
					if (!slot_ok) begin
						status = ST_BAD_SLOT;
						halt   = 1'b1;
					end else if (full) begin
						status = ST_OVERFLOW;
						halt   = 1'b1;
					end else begin
						stk_we = 1'b1;
						stk_wd = val;
						tos_n  = val;
						sp_n   = sp_q + 1'b1;
					end
				end
				K_STORE: begin
					if (!slot_ok) begin
						status = ST_BAD_SLOT;
						halt   = 1'b1;
					end else if (!ge1) begin
						status = ST_UNDERFLOW;
						halt   = 1'b1;
					end else begin
						loc_we = 1'b1;
						loc_wd = tos_q;
						tos_n  = a2;
						sp_n   = sp_q - 1'b1;
					end
				end
				K_JMP: jump = 1'b1;
				K_JMPN, K_JMPT: begin
					if (!ge1) begin
						status = ST_UNDERFLOW;
						halt   = 1'b1;
					end else begin
						jump  = (k == K_JMPT) == !bz;
						tos_n = a2;
						sp_n  = sp_q - 1'b1;
					end
				end
				default: begin
					status = ST_HALTED;
					halt   = 1'b1;
				end
			endcase
		end
		pc_n = halt ? pc_q : jump ? target : pc_q + 16'(kind_len(k));
	end

	assign stat.need_div = need_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q     <= '0;
			pc_q     <= '0;
			halted_q <= 1'b0;
			nloc_q   <= NLOC_RESET;
		end else begin
			if (cfg_we)
				nloc_q <= cfg_wdata;
			if (cmd.commit) begin
				sp_q     <= sp_n;
				pc_q     <= pc_n;
				halted_q <= halt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			item_q <= in_data;
		if (cmd.commit) begin
			tos_q                <= tos_n;
			out_data.next_pc     <= pc_n;
			out_data.top_value   <= (sp_n != '0) ? 32'(tos_n) : '0;
			out_data.stack_depth <= 7'(sp_n);
			out_data.status      <= status;
		end
	end

	a_halt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && halted_q |=> halted_q && $stable(sp_q) && $stable(pc_q))
		else $error("halted state changed");
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH)) else $error("stack pointer out of range");

endmodule

[src/sbe_ctrl.sv]
`timescale 1ns / 1ps

module sbe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  sbe_pkg::sbe_stat_t stat,
	output sbe_pkg::sbe_cmd_t  cmd
);
	import sbe_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DIV  = 3'b100
	} state_t;

	state_t state_q;
	logic   out_free;

	assign out_free      = !out_valid || out_ready;
	assign in_ready      = state_q == S_IDLE;
	assign cmd.capture   = in_valid && in_ready;
	assign cmd.start_div = state_q == S_EXEC && stat.need_div;
	assign cmd.commit    = out_free && ((state_q == S_EXEC && !stat.need_div)
		|| (state_q == S_DIV && stat.div_done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			out_valid <= cmd.commit || (out_valid && !out_ready);
			unique case (state_q)
				S_IDLE: if (cmd.capture) state_q <= S_EXEC;
				S_EXEC: begin
					if (cmd.start_div)
						state_q <= S_DIV;
					else if (cmd.commit)
						state_q <= S_IDLE;
				end
				S_DIV: if (cmd.commit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid && !out_ready)) else $error("result overwritten");
	a_div_enter: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_div |=> state_q == S_DIV) else $error("divide not entered");
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid && state_q == S_IDLE) else $error("commit lost");

endmodule

[src/stack_bytecode_exec_core.sv]
`timescale 1ns / 1ps
// Stack bytecode execution core.
// Input channel (in_valid/in_ready/in_data): one decoded instruction per request,
// carrying kind, big-endian operand word and the prefetched constant.
// Output channel (out_valid/out_ready/out_data): one result per request with
// next pc, top of stack (zero when empty), stack depth and status.
// Configuration: cfg_we writes cfg_wdata into the local slot limit at once;
// write it only while the core is idle.
// Timing: a request is taken in the idle state, the stack and local memories
// are read on that edge and the result is registered from the execute state
// once the output register is free. Div, mod and divide-into-local instead
// start the radix-2 divider from the execute state and register the result
// from the divide state once the divider is done and the output register is
// free. No new request is taken until then, as in_ready is high only in idle.
// A new request is accepted while a result still waits in the output
// register; a stalled receiver holds the next result in the core until
// the output register frees, and no further request is taken meanwhile.
// Reset clears stack depth, pc and the halt flag and sets the slot limit to
// 256; stack and local memory contents are not cleared.
// Once halted, every request reports status halted until reset.
module stack_bytecode_exec_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sbe_pkg::sbe_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sbe_pkg::sbe_out_t out_data,
	input  logic              cfg_we,
	input  logic [8:0]        cfg_wdata
);
	import sbe_pkg::*;

	sbe_cmd_t  cmd;
	sbe_stat_t stat;

	sbe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	sbe_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata), .cmd(cmd), .stat(stat), .out_data(out_data)
	);

endmodule

[bench/sbe_result_checker.sv]
`timescale 1ns / 1ps

module sbe_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  sbe_pkg::sbe_in_t               in_data,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  sbe_pkg::sbe_out_t              out_data,
	input  logic                           cfg_we,
	input  logic [8:0]                     cfg_wdata,
	output int                             fail_count,
	output int                             pending,
	output int                             depth_now,
	output logic [8:0]                     slot_limit,
	output logic                           is_halted,
	output logic [sbe_pkg::LOCAL_COUNT-1:0] slot_written
);
	import sbe_pkg::*;

	data_t       opstack [STACK_DEPTH];
	data_t       locals [LOCAL_COUNT];
	int          sp = 0;
	logic [15:0] pc = '0;
	logic        halted = 1'b0;
	logic [8:0]  lim = NLOC_RESET;
	logic [LOCAL_COUNT-1:0] written = '0;
	sbe_out_t    expected_results[$];
	int          fails = 0;

	assign fail_count   = fails;
	assign pending      = expected_results.size();
	assign depth_now    = sp;
	assign slot_limit   = lim;
	assign is_halted    = halted;
	assign slot_written = written;

	function automatic data_t sdiv(data_t a, data_t b, bit want_mod);
		if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
			return want_mod ? data_t'(0) : a;
		return want_mod ? data_t'($signed(a) % $signed(b)) : data_t'($signed(a) / $signed(b));
	endfunction

	function automatic bit slot_good(logic [15:0] s);
		return s < lim && s < LOCAL_COUNT;
	endfunction

	function automatic sbe_out_t execute_insn(sbe_in_t x);
		sbe_out_t o;
		status_t  st;
		logic [15:0] target;
		logic [1:0] len;
		bit halt, jump;
		data_t a, b, r;
		st = ST_OK;
		halt = 0;
		jump = 0;
		r = '0;
		len = 2'd1;
		if (halted) begin
			st = ST_HALTED;
		end else begin
			if (x.kind == K_PUSHC || (x.kind >= K_ADDS && x.kind <= K_DIVS) ||
				(x.kind >= K_LOAD && x.kind <= K_JMPT))
				len = 2'd3;
			target = pc + 16'd3 + x.operand_word;
			case (x.kind)
				K_PUSHC, K_TRUE, K_FALSE: begin
					if (sp >= STACK_DEPTH) begin
						st = ST_OVERFLOW;
						halt = 1;
					end else begin
						opstack[sp] = x.kind == K_PUSHC ? data_t'(x.constant_value) :
							(x.kind == K_TRUE ? data_t'(1) : data_t'(0));
						sp++;
					end
				end
				K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_GT, K_GTE, K_LT, K_LTE,
				K_IEQ, K_BEQ, K_INEQ, K_BNEQ: begin
					if (sp < 2) begin
						st = ST_UNDERFLOW;
						halt = 1;
					end else begin
						b = opstack[sp-1];
						a = opstack[sp-2];
						if ((x.kind == K_DIV || x.kind == K_MOD) && b == 0) begin
							st = ST_DIV_ZERO;
						end else begin
							case (x.kind)
								K_ADD: r = a + b;
								K_SUB: r = a - b;
								K_MUL: r = a * b;
								K_DIV: r = sdiv(a, b, 0);
								K_MOD: r = sdiv(a, b, 1);
								K_GT:  r = data_t'($signed(a) > $signed(b));
								K_GTE: r = data_t'($signed(a) >= $signed(b));
								K_LT:  r = data_t'($signed(a) < $signed(b));
								K_LTE: r = data_t'($signed(a) <= $signed(b));
								K_IEQ: r = data_t'(a == b);
								K_BEQ: r = data_t'((a != 0) == (b != 0));
								K_INEQ: r = data_t'(a != b);
								default: r = data_t'((a != 0) != (b != 0));
							endcase
							sp--;
							opstack[sp-1] = r;
						end
					end
				end
				K_ADDS, K_SUBS, K_MULS, K_DIVS: begin
					if (sp < 1) begin
						st = ST_UNDERFLOW;
						halt = 1;
					end else if (!slot_good(x.operand_word)) begin
						st = ST_BAD_SLOT;
						halt = 1;
					end else begin
						b = opstack[sp-1];
						a = locals[x.operand_word[7:0]];
						if (x.kind == K_DIVS && b == 0) begin
							st = ST_DIV_ZERO;
						end else begin
							case (x.kind)
								K_ADDS: r = a + b;
								K_SUBS: r = a - b;
								K_MULS: r = a * b;
								default: r = sdiv(a, b, 0);
							endcase
							locals[x.operand_word[7:0]] = r;
							sp--;
						end
					end
				end
				K_NEG, K_NOT: begin
					if (sp < 1) begin
						st = ST_UNDERFLOW;
						halt = 1;
					end else begin
						a = opstack[sp-1];
						opstack[sp-1] = x.kind == K_NEG ? -a : data_t'(a == 0);
					end
				end
				K_LOAD: begin
					if (!slot_good(x.operand_word)) begin
						st = ST_BAD_SLOT;
						halt = 1;
					end else if (sp >= STACK_DEPTH) begin
						st = ST_OVERFLOW;
						halt = 1;
					end else begin
						opstack[sp] = locals[x.operand_word[7:0]];
						sp++;
					end
				end
				K_STORE: begin
					if (!slot_good(x.operand_word)) begin
						st = ST_BAD_SLOT;
						halt = 1;
					end else if (sp < 1) begin
						st = ST_UNDERFLOW;
						halt = 1;
					end else begin
						sp--;
						locals[x.operand_word[7:0]] = opstack[sp];
						written[x.operand_word[7:0]] = 1'b1;
					end
				end
				K_JMP: jump = 1;
				K_JMPN, K_JMPT: begin
					if (sp < 1) begin
						st = ST_UNDERFLOW;
						halt = 1;
					end else begin
						sp--;
						jump = (x.kind == K_JMPT) == (opstack[sp] != 0);
					end
				end
				default: begin
					st = ST_HALTED;
					halt = 1;
				end
			endcase
			if (halt)
				halted = 1'b1;
			else if (jump)
				pc = target;
			else
				pc = pc + 16'(len);
		end
		o.next_pc     = pc;
		o.top_value   = sp != 0 ? opstack[sp-1] : '0;
		o.stack_depth = 7'(sp);
		o.status      = st;
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		sbe_out_t want;
		if (!arst_n) begin
			sp = 0;
			pc = '0;
			halted = 1'b0;
			lim = NLOC_RESET;
		end else begin
			if (cfg_we)
				lim = cfg_wdata;
			if (in_valid && in_ready)
				expected_results.push_back(execute_insn(in_data));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", out_data, 0);
				end else begin
					want = expected_results.pop_front();
					if (out_data.next_pc !== want.next_pc)
						report_mismatch("next_pc", out_data.next_pc, want.next_pc);
					if (out_data.top_value !== want.top_value)
						report_mismatch("top_value", out_data.top_value, want.top_value);
					if (out_data.stack_depth !== want.stack_depth)
						report_mismatch("stack_depth", out_data.stack_depth, want.stack_depth);
					if (out_data.status !== want.status)
						report_mismatch("status", out_data.status, want.status);
				end
			end
		end
	end

endmodule

[bench/tb_stack_bytecode_exec_core.sv]
`timescale 1ns / 1ps

module tb_stack_bytecode_exec_core;
	import sbe_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	sbe_in_t    in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	sbe_out_t   out_data;
	logic       cfg_we = 1'b0;
	logic [8:0] cfg_wdata = '0;

	int         fail_count, pending, depth_now;
	logic [8:0] slot_limit;
	logic       is_halted;
	logic [LOCAL_COUNT-1:0] slot_written;
	bit         no_idle = 0;
	int         cycles = 0;

	always #2 clk = ~clk;

	stack_bytecode_exec_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	sbe_result_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending), .depth_now(depth_now),
		.slot_limit(slot_limit), .is_halted(is_halted), .slot_written(slot_written)
	);

	always @(negedge clk)
		out_ready <= no_idle || ($urandom_range(99) >= 13);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_insn(kind_t k, logic [15:0] opw, logic [31:0] cv);
		while (!no_idle && $urandom_range(99) < 13)
			@(negedge clk);
		in_valid = 1'b1;
		in_data.kind = k;
		in_data.operand_word = opw;
		in_data.constant_value = cv;
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_limit(logic [8:0] v);
		drain();
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0;
			4, 5: return 32'($signed($urandom_range(20)) - 10);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_insn();
		kind_t       k;
		logic [15:0] opw;
		bit          legal;
		int          tries;
		legal = 0;
		while (!legal) begin
			k = kind_t'($urandom_range(26));
			if (depth_now < 3 && $urandom_range(1))
				k = kind_t'($urandom_range(2));
			opw = 16'($urandom);
			case (k)
				K_PUSHC, K_TRUE, K_FALSE: legal = depth_now < STACK_DEPTH;
				K_NEG, K_NOT, K_JMPN, K_JMPT: legal = depth_now >= 1;
				K_JMP: legal = 1;
				K_STORE: begin
					if (slot_limit != 0) begin
						opw = 16'($urandom_range(1) ? $urandom_range(15) : $urandom_range(255));
						if (opw >= slot_limit)
							opw = 16'($urandom_range(slot_limit - 1));
						legal = depth_now >= 1;
					end
				end
				K_ADDS, K_SUBS, K_MULS, K_DIVS, K_LOAD: begin
					for (tries = 0; tries < 8 && !legal; tries++) begin
						opw = 16'($urandom_range(1) ? $urandom_range(15) : $urandom_range(255));
						legal = opw < slot_limit && slot_written[opw[7:0]];
					end
					if (k == K_LOAD)
						legal = legal && depth_now < STACK_DEPTH;
					else
						legal = legal && depth_now >= 1;
				end
				default: legal = depth_now >= 2;
			endcase
		end
		send_insn(k, opw, rand_value());
	endtask

	initial begin
		int i;
		int halt_cause;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_insn(K_TRUE, 16'h0, 32'h0);
		send_insn(K_FALSE, 16'hFFFF, 32'hFFFF_FFFF);
		send_insn(K_BEQ, 16'h0, 32'h0);
		send_insn(K_NOT, 16'h0, 32'h0);
		send_insn(K_PUSHC, 16'h0, 32'h7FFF_FFFF);
		send_insn(K_ADD, 16'h0, 32'h0);
		send_insn(K_PUSHC, 16'h0, 32'hFFFF_FFFF);
		send_insn(K_DIV, 16'h0, 32'h0);
		send_insn(K_PUSHC, 16'h0, 32'hFFFF_FFFF);
		send_insn(K_MOD, 16'h0, 32'h0);
		send_insn(K_PUSHC, 16'h0, 32'h0);
		send_insn(K_DIV, 16'h0, 32'h0);
		send_insn(K_MOD, 16'h0, 32'h0);
		send_insn(K_SUB, 16'h0, 32'h0);
		send_insn(K_PUSHC, 16'h0, -32'sd7);
		send_insn(K_STORE, 16'd255, 32'h0);
		send_insn(K_PUSHC, 16'h0, 32'd3);
		send_insn(K_DIVS, 16'd255, 32'h0);
		send_insn(K_LOAD, 16'd255, 32'h0);
		send_insn(K_MULS, 16'd255, 32'h0);
		send_insn(K_DIVS, 16'd255, 32'h0);
		send_insn(K_ADDS, 16'd255, 32'h0);
		send_insn(K_LOAD, 16'd255, 32'h0);
		send_insn(K_PUSHC, 16'h0, -32'sd5);
		send_insn(K_SUBS, 16'd255, 32'h0);
		send_insn(K_PUSHC, 16'h0, 32'h8000_0000);
		send_insn(K_MUL, 16'h0, 32'h0);
		send_insn(K_NEG, 16'h0, 32'h0);
		send_insn(K_PUSHC, 16'h0, 32'd9);
		send_insn(K_GT, 16'h0, 32'h0);
		send_insn(K_PUSHC, 16'h0, 32'd1);
		send_insn(K_GTE, 16'h0, 32'h0);
		send_insn(K_TRUE, 16'h0, 32'h0);
		send_insn(K_LT, 16'h0, 32'h0);
		send_insn(K_TRUE, 16'h0, 32'h0);
		send_insn(K_LTE, 16'h0, 32'h0);
		send_insn(K_TRUE, 16'h0, 32'h0);
		send_insn(K_IEQ, 16'h0, 32'h0);
		send_insn(K_TRUE, 16'h0, 32'h0);
		send_insn(K_INEQ, 16'h0, 32'h0);
		send_insn(K_TRUE, 16'h0, 32'h0);
		send_insn(K_BNEQ, 16'h0, 32'h0);
		send_insn(K_JMP, 16'hFFF0, 32'h0);
		send_insn(K_TRUE, 16'h0, 32'h0);
		send_insn(K_JMPT, 16'h0100, 32'h0);
		send_insn(K_JMPN, 16'h8000, 32'h0);

		write_limit(9'd1);
		for (i = 0; i < 300; i++)
			random_insn();
		write_limit(9'd0);
		for (i = 0; i < 200; i++)
			random_insn();
		write_limit(9'($urandom_range(2, 255)));
		no_idle = 1;
		for (i = 0; i < 300; i++)
			random_insn();
		no_idle = 0;
		drain();
		for (i = 0; i < 200; i++)
			random_insn();
		write_limit(9'd255);
		for (i = 0; i < 350; i++)
			random_insn();
		write_limit(9'd256);
		for (i = 0; i < 450; i++)
			random_insn();

		halt_cause = $urandom_range(3);
		case (halt_cause)
			0: begin
				while (depth_now < STACK_DEPTH)
					send_insn(K_TRUE, 16'h0, 32'h0);
				send_insn(K_PUSHC, 16'h0, $urandom);
			end
			1: begin
				while (depth_now > 0)
					send_insn(K_JMPN, 16'($urandom), 32'h0);
				send_insn(K_ADD, 16'h0, 32'h0);
			end
			2: send_insn(K_LOAD, 16'hFFFF, 32'h0);
			default: send_insn(kind_t'($urandom_range(27, 31)), 16'($urandom), $urandom);
		endcase
		for (i = 0; i < 12; i++)
			send_insn(kind_t'(i < 5 ? 27 + i : $urandom_range(31)), 16'($urandom), $urandom);

		drain();
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
